[src/agbk_pkg.sv]
// ----------------------------------------------------------------------------
// agbk_pkg: shared types and constants
// widths, register indexes and sequencer states of the angle/bias filter
// ----------------------------------------------------------------------------
`default_nettype none
package agbk_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CfgW  = 31;
  localparam int unsigned IdxW  = 2;

  localparam logic [IdxW-1:0] RegTimeStep   = 2'd0;
  localparam logic [IdxW-1:0] RegAngleNoise = 2'd1;
  localparam logic [IdxW-1:0] RegBiasNoise  = 2'd2;
  localparam logic [IdxW-1:0] RegMeasNoise  = 2'd3;

  localparam logic [CfgW-1:0] TimeStepRst   = 31'd10737418;
  localparam logic [CfgW-1:0] AngleNoiseRst = 31'd214748;
  localparam logic [CfgW-1:0] BiasNoiseRst  = 31'd322123;
  localparam logic [CfgW-1:0] MeasNoiseRst  = 31'd21474836;
  localparam logic signed [DataW-1:0] OneQ30 = 32'sh4000_0000;

  localparam logic signed [DataW-1:0] SatMax = 32'sh7fff_ffff;
  localparam logic signed [DataW-1:0] SatMin = 32'sh8000_0000;

  // micro-op codes of the shared serial multiplier and divider
  typedef enum logic [3:0] {
    OP_PRED_ANGLE, OP_PRED_AA, OP_PRED_AB, OP_PRED_BB,
    OP_DIV0, OP_DIV1,
    OP_CORR_AA, OP_CORR_AB, OP_CORR_BA, OP_CORR_BB,
    OP_CORR_ANG, OP_CORR_BIAS
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SETUP, ST_MUL, ST_DIV, ST_APPLY, ST_OUT
  } state_t;

  function automatic logic signed [DataW-1:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return SatMax;
    if (v < -66'sd2147483648) return SatMin;
    return v[DataW-1:0];
  endfunction

  // round half up from Q(x+30) to Qx: add 2^29 then arithmetic shift
  function automatic logic signed [65:0] rnd30(input logic signed [65:0] v);
    logic signed [65:0] t;
    t = v + 66'sd536870912;
    return t >>> 30;
  endfunction

endpackage
`default_nettype wire

[src/agbk_if.sv]
// ----------------------------------------------------------------------------
// agbk_if: valid/ready channel carrying two 32-bit fields
// used for both the sample input and the result output
// ----------------------------------------------------------------------------
`default_nettype none
interface agbk_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] f0;
  logic signed [31:0] f1;
  modport source (output valid, output f0, output f1, input ready);
  modport sink (input valid, input f0, input f1, output ready);
endinterface
`default_nettype wire

[src/agbk_smul.sv]
// ----------------------------------------------------------------------------
// agbk_smul: bit-serial signed multiplier
// 32-bit by 33-bit, one multiplier bit per cycle, shift-add over the 33 multiplier bits
// product is exact in 64 bits for the operand ranges the filter uses
// ----------------------------------------------------------------------------
`default_nettype none
module agbk_smul (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [31:0] a,
  input  wire logic signed [32:0] b,
  output logic                    done,
  output logic signed [63:0]      prod
);
  import agbk_pkg::*;

  logic signed [63:0] acc_r, acc_nxt;
  logic signed [63:0] mcand_r, mcand_nxt;
  logic [32:0]        mplier_r, mplier_nxt;
  logic [5:0]         cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;

  always_comb begin
    acc_nxt = acc_r;
    mcand_nxt = mcand_r;
    mplier_nxt = mplier_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done = 1'b0;
    if (start) begin
      acc_nxt = '0;
      mcand_nxt = {{32{a[31]}}, a};
      mplier_nxt = b;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // top bit of the multiplier has negative weight
      if (mplier_r[0]) begin
        if (cnt_r == 6'd32) acc_nxt = acc_r - mcand_r;
        else acc_nxt = acc_r + mcand_r;
      end
      mcand_nxt = mcand_r <<< 1;
      mplier_nxt = mplier_r >> 1;
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd32) begin
        busy_nxt = 1'b0;
        done = 1'b1;
      end
    end
  end

  assign prod = acc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    mcand_r <= mcand_nxt;
    mplier_r <= mplier_nxt;
  end
endmodule
`default_nettype wire

[src/agbk_sdiv.sv]
// ----------------------------------------------------------------------------
// agbk_sdiv: radix-2 restoring divider
// signed n * 2^30 / d truncated toward zero, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module agbk_sdiv (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [31:0] num,
  input  wire logic signed [32:0] den,
  output logic                    done,
  output logic signed [31:0]      quo
);
  import agbk_pkg::*;

  // |num|*2^30 < 2^62, |den| < 2^33; quotient needs up to 62 bits
  logic [61:0] q_r, q_nxt;
  logic [33:0] rem_r, rem_nxt;
  logic [32:0] dabs_r, dabs_nxt;
  logic        neg_r, neg_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [33:0] trial;
  logic [61:0] nabs;
  logic [65:0] sq;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    dabs_nxt = dabs_r;
    neg_nxt = neg_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done = 1'b0;
    trial = '0;
    nabs = {(num[31] ? 32'(-num) : 32'(num)), 30'd0};
    if (start) begin
      q_nxt = nabs;
      rem_nxt = '0;
      dabs_nxt = den[32] ? 33'(-den) : 33'(den);
      neg_nxt = num[31] ^ den[32];
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      trial = {rem_r[32:0], q_r[61]};
      q_nxt = {q_r[60:0], 1'b0};
      if (trial >= {1'b0, dabs_r}) begin
        rem_nxt = trial - {1'b0, dabs_r};
        q_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial;
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd61) begin
        busy_nxt = 1'b0;
        done = 1'b1;
      end
    end
  end

  // quotient taken in the done cycle, so the last bit comes from q_nxt
  always_comb begin
    sq = neg_r ? -{4'd0, q_nxt} : {4'd0, q_nxt};
    quo = sat32(sq);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    dabs_r <= dabs_nxt;
    neg_r <= neg_nxt;
  end
endmodule
`default_nettype wire

[src/angle_gyro_bias_kalman_filter.sv]
// ----------------------------------------------------------------------------
// angle_gyro_bias_kalman_filter: two-state angle / gyro bias filter
// steps after a sample is taken: 4 prediction products, apply, 2 divisions,
// 6 correction products, out; each product is a setup step and the serial
// multiplier steps; one word at a time, the bit-serial multiplier serving all
// products and the radix-2 divider both divisions; zero innovation variance
// skips the divisions and corrections; a stalled result holds the input off
// reset (synchronous, active low) restores configuration registers and filter state
// ----------------------------------------------------------------------------
`default_nettype none
module angle_gyro_bias_kalman_filter (
  input  wire logic              clk,
  input  wire logic              rst_n,
  agbk_if.sink                   in_ch,
  agbk_if.source                 out_ch,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_idx,
  input  wire logic [30:0]       cfg_data
);
  import agbk_pkg::*;

  // configuration registers
  logic [CfgW-1:0] dt_r, qa_r, qb_r, rm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r <= TimeStepRst;
      qa_r <= AngleNoiseRst;
      qb_r <= BiasNoiseRst;
      rm_r <= MeasNoiseRst;
    end else if (cfg_we) begin
      case (cfg_idx)
        RegTimeStep:   dt_r <= cfg_data;
        RegAngleNoise: qa_r <= cfg_data;
        RegBiasNoise:  qb_r <= cfg_data;
        RegMeasNoise:  rm_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // filter state
  logic signed [31:0] ang_r, ang_nxt, bias_r, bias_nxt;
  logic signed [31:0] paa_r, paa_nxt, pab_r, pab_nxt, pba_r, pba_nxt;
  logic signed [31:0] pbb_r, pbb_nxt;
  // per-sample working values
  logic signed [31:0] meas_r, meas_nxt, rate_r, rate_nxt;
  logic signed [31:0] err_r, err_nxt, k0_r, k0_nxt, k1_r, k1_nxt;
  logic signed [31:0] pc0_r, pc0_nxt, t1_r, t1_nxt;
  logic signed [32:0] e_r, e_nxt;
  logic signed [31:0] ra_r, ra_nxt;
  // cross-term step of the prediction, kept unsaturated until it is added
  logic signed [33:0] rb_r, rb_nxt;
  logic signed [31:0] ao_r, ao_nxt, ro_r, ro_nxt;
  op_t    op_r, op_nxt;
  state_t st_r, st_nxt;

  // shared serial multiplier and divider
  logic               mul_start, mul_done, div_start, div_done;
  logic signed [31:0] mul_a, div_num, q;
  logic signed [32:0] mul_b;
  logic signed [63:0] prod;

  agbk_smul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(prod)
  );

  agbk_sdiv u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(e_r),
    .done(div_done), .quo(q)
  );

  // rate minus bias is exact within 33 bits; the angle prediction takes it
  // unsaturated on the 33-bit multiplier input with dt on the other side
  logic signed [65:0] rd;
  assign rd = 66'(rate_r) - 66'(bias_r);

  // operand select for the multiplier
  logic signed [65:0] inner_w;
  always_comb begin
    inner_w = 66'($signed({1'b0, qa_r})) - 66'(pab_r) - 66'(pba_r);
    mul_a = '0;
    mul_b = $signed({2'b0, dt_r});
    case (op_r)
      OP_PRED_ANGLE: begin mul_a = $signed({1'b0, dt_r}); mul_b = rd[32:0]; end
      OP_PRED_AA:    mul_a = sat32(inner_w);
      OP_PRED_AB:    mul_a = pbb_r;  // negated after the product
      OP_PRED_BB:    mul_a = $signed({1'b0, qb_r});
      OP_CORR_AA:   begin mul_a = k0_r; mul_b = 33'(pc0_r); end
      OP_CORR_AB:   begin mul_a = k0_r; mul_b = 33'(t1_r);  end
      OP_CORR_BA:   begin mul_a = k1_r; mul_b = 33'(pc0_r); end
      OP_CORR_BB:   begin mul_a = k1_r; mul_b = 33'(t1_r);  end
      OP_CORR_ANG:  begin mul_a = k0_r; mul_b = 33'(err_r); end
      OP_CORR_BIAS: begin mul_a = k1_r; mul_b = 33'(err_r); end
      default: ;
    endcase
  end
  logic signed [65:0] pr, prn;
  assign pr = rnd30(66'(prod));
  // round half up of the negated product, as the cross terms need
  assign prn = rnd30(-66'(prod));
  assign div_num = (op_r == OP_DIV0) ? pc0_r : pba_r;

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:  if (in_ch.valid) st_nxt = ST_SETUP;
      ST_SETUP: st_nxt = ST_MUL;
      ST_MUL: begin
        if (mul_done) begin
          if (op_r == OP_PRED_BB) st_nxt = ST_APPLY;
          else if (op_r == OP_CORR_BIAS) st_nxt = ST_OUT;
          else st_nxt = ST_SETUP;
        end
      end
      ST_APPLY: st_nxt = (e_nxt == 33'sd0) ? ST_OUT : ST_DIV;
      ST_DIV: begin
        if (div_done && op_r == OP_DIV1) st_nxt = ST_SETUP;
        else if (div_done) st_nxt = ST_DIV;
      end
      ST_OUT: if (!out_ch.valid || out_ch.ready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  logic div_go_r, div_go_nxt;
  always_comb begin
    ang_nxt = ang_r; bias_nxt = bias_r;
    paa_nxt = paa_r; pab_nxt = pab_r; pba_nxt = pba_r; pbb_nxt = pbb_r;
    meas_nxt = meas_r; rate_nxt = rate_r; err_nxt = err_r;
    k0_nxt = k0_r; k1_nxt = k1_r; pc0_nxt = pc0_r; t1_nxt = t1_r; e_nxt = e_r;
    ra_nxt = ra_r; rb_nxt = rb_r; ao_nxt = ao_r; ro_nxt = ro_r;
    op_nxt = op_r;
    in_ch.ready = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    div_go_nxt = 1'b0;
    case (st_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          meas_nxt = in_ch.f0;
          rate_nxt = in_ch.f1;
          op_nxt = OP_PRED_ANGLE;
        end
      end
      ST_SETUP: mul_start = 1'b1;
      ST_MUL: begin
        if (mul_done) begin
          case (op_r)
            OP_PRED_ANGLE: begin ang_nxt = sat32(66'(ang_r) + pr); op_nxt = OP_PRED_AA; end
            OP_PRED_AA:    begin ra_nxt = sat32(66'(paa_r) + pr); op_nxt = OP_PRED_AB; end
            OP_PRED_AB:    begin rb_nxt = prn[33:0]; op_nxt = OP_PRED_BB; end
            OP_PRED_BB:    pbb_nxt = sat32(66'(pbb_r) + pr);
            OP_CORR_AA:    begin paa_nxt = sat32(66'(paa_r) - pr); op_nxt = OP_CORR_AB; end
            OP_CORR_AB:    begin pab_nxt = sat32(66'(pab_r) - pr); op_nxt = OP_CORR_BA; end
            OP_CORR_BA:    begin pba_nxt = sat32(66'(pba_r) - pr); op_nxt = OP_CORR_BB; end
            OP_CORR_BB:    begin pbb_nxt = sat32(66'(pbb_r) - pr); op_nxt = OP_CORR_ANG; end
            OP_CORR_ANG:   begin ang_nxt = sat32(66'(ang_r) + pr); op_nxt = OP_CORR_BIAS; end
            OP_CORR_BIAS: begin
              bias_nxt = sat32(66'(bias_r) + pr);
              ao_nxt = ang_r;
              ro_nxt = sat32(66'(rate_r) - 66'(bias_nxt));
            end
            default: ;
          endcase
        end
      end
      ST_APPLY: begin
        // commit predicted covariance, form innovation and its variance
        paa_nxt = ra_r;
        pab_nxt = sat32(66'(pab_r) + 66'(rb_r));
        pba_nxt = sat32(66'(pba_r) + 66'(rb_r));
        err_nxt = sat32(66'(meas_r) - 66'(ang_r));
        pc0_nxt = ra_r;
        t1_nxt = sat32(66'(pab_r) + 66'(rb_r));
        e_nxt = 33'($signed({1'b0, rm_r})) + 33'(ra_r);
        k0_nxt = '0;
        k1_nxt = '0;
        op_nxt = OP_DIV0;
        div_go_nxt = 1'b1;
        if (e_nxt == 33'sd0) begin
          ao_nxt = ang_r;
          ro_nxt = sat32(rd);
        end
      end
      ST_DIV: begin
        div_start = div_go_r;
        if (div_done) begin
          if (op_r == OP_DIV0) begin
            k0_nxt = q; op_nxt = OP_DIV1; div_go_nxt = 1'b1;
          end else begin
            k1_nxt = q; op_nxt = OP_CORR_AA;
          end
        end
      end
      default: ;
    endcase
  end

  // result register parts the two sides
  logic out_valid_r, out_valid_nxt;
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) out_valid_nxt = 1'b0;
    if (st_r == ST_OUT && (!out_valid_r || out_ch.ready)) out_valid_nxt = 1'b1;
  end
  logic signed [31:0] oa_r, or_r;
  assign out_ch.valid = out_valid_r;
  assign out_ch.f0 = oa_r;
  assign out_ch.f1 = or_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      out_valid_r <= 1'b0;
      div_go_r <= 1'b0;
      ang_r <= '0; bias_r <= '0;
      paa_r <= OneQ30; pab_r <= '0; pba_r <= '0; pbb_r <= OneQ30;
    end else begin
      st_r <= st_nxt;
      out_valid_r <= out_valid_nxt;
      div_go_r <= div_go_nxt;
      ang_r <= ang_nxt; bias_r <= bias_nxt;
      paa_r <= paa_nxt; pab_r <= pab_nxt; pba_r <= pba_nxt; pbb_r <= pbb_nxt;
    end
    if (st_r == ST_OUT && (!out_valid_r || out_ch.ready)) begin
      oa_r <= ao_r;
      or_r <= ro_r;
    end
    meas_r <= meas_nxt; rate_r <= rate_nxt; err_r <= err_nxt;
    k0_r <= k0_nxt; k1_r <= k1_nxt; pc0_r <= pc0_nxt; t1_r <= t1_nxt; e_r <= e_nxt;
    ra_r <= ra_nxt; rb_r <= rb_nxt; ao_r <= ao_nxt; ro_r <= ro_nxt;
    op_r <= op_nxt;
  end
endmodule
`default_nettype wire

[src/agbk_checker.sv]
// ----------------------------------------------------------------------------
// agbk_checker: port-level assertions for the angle/bias filter
// bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
module agbk_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [31:0] out_a
);
  // a stalled result stays valid and its angle field holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_a))
    else $error("result word changed under stall");
  // no new sample right after one is taken
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("sample taken while busy");
  // reset leaves no result pending
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind angle_gyro_bias_kalman_filter agbk_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_a(out_ch.f0)
);
`default_nettype wire
